### src/bfd_pkg.sv
// Package for the Boolean function degree core.
// Holds shared constants, the controller state type and the command and status structs.
// No dependencies.
package bfd_pkg;

    localparam int BFD_MAX_VARS = 8;
    localparam int BFD_NV_W = 4;
    localparam logic [BFD_NV_W-1:0] BFD_NV_RESET = 4'd8;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_XREAD,
        ST_XWRITE,
        ST_SCAN,
        ST_EMIT
    } bfd_state_t;

    typedef struct packed {
        logic cfg_write;
        logic load;
        logic xread;
        logic xwrite;
        logic scan;
        logic emit;
    } bfd_cmd_t;

    typedef struct packed {
        logic load_last;
        logic xform_last;
        logic scan_last;
    } bfd_sts_t;

endpackage

### src/boolean_function_degree_core.sv
// Top level of the Boolean function degree core.
// Instantiates bfd_ctrl and bfd_datapath; depends on bfd_pkg.
//
// Usage:
//   cfg_valid/cfg_ready/cfg_data write num_vars (n). Values of 0 act as 1, values above
//   MAX_VARS act as MAX_VARS. Write only between functions.
//   in_valid/in_ready/truth_bit carry the truth table, one entry per request, index 0 first.
//   out_valid/out_ready/degree carry one result per function: its algebraic degree.
// Sequence: after the request with the last entry, n rounds of 2^(n-1) butterfly pairs,
//   each pair read (both entries) and then written (the upper one), then a scan over the
//   table, then the degree is loaded into the output register.
// Busy: no request is taken during the transform and the scan, so a new table cannot load
//   before the last one is scanned; the serial butterfly sets the busy part.
// Reset: num_vars returns to 8, the load count to 0, no result pending; the table memory
//   is undefined until loaded.
// Stall: loading of the next table goes on while a result waits; once the next degree is
//   ready the block holds it and takes no request until the waiting result is taken.
module boolean_function_degree_core
    import bfd_pkg::*;
#(
    parameter int MAX_VARS = BFD_MAX_VARS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [BFD_NV_W-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                truth_bit,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BFD_NV_W-1:0] degree
);

    bfd_cmd_t cmd;
    bfd_sts_t sts;

    bfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bfd_datapath #(
        .MAX_VARS (MAX_VARS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_data  (cfg_data),
        .truth_bit (truth_bit),
        .degree    (degree)
    );

endmodule

### src/bfd_datapath.sv
// Datapath of the Boolean function degree core: num_vars register, table memory,
// butterfly pair and scan counters, degree register.
// Depends on bfd_pkg.
module bfd_datapath
    import bfd_pkg::*;
#(
    parameter int MAX_VARS = BFD_MAX_VARS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  bfd_cmd_t            cmd,
    output bfd_sts_t            sts,
    input  logic [BFD_NV_W-1:0] cfg_data,
    input  logic                truth_bit,
    output logic [BFD_NV_W-1:0] degree
);

    localparam int DEPTH = 1 << MAX_VARS;
    localparam int CNT_W = MAX_VARS;
    localparam int RND_W = $clog2(MAX_VARS + 1);

    logic [BFD_NV_W-1:0] num_vars_reg, num_vars_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [RND_W-1:0]    round_reg, round_next;
    logic [CNT_W-1:0]    pair_reg, pair_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                check_reg, check_next;
    logic [BFD_NV_W-1:0] weight_reg, weight_next;
    logic [BFD_NV_W-1:0] best_reg, best_next;
    logic [BFD_NV_W-1:0] degree_reg, degree_next;
    logic                rd0_reg, rd1_reg;
    logic                table_mem [DEPTH];

    logic [BFD_NV_W-1:0] n_eff;
    logic [CNT_W:0]      table_len;
    logic [CNT_W:0]      half_len;
    logic [CNT_W-1:0]    bit_sel;
    logic [CNT_W-1:0]    low_mask;
    logic [CNT_W-1:0]    addr_lo;
    logic [CNT_W-1:0]    addr_hi;
    logic [CNT_W-1:0]    rd0_addr;
    logic [CNT_W-1:0]    wr_addr;
    logic                wr_en;
    logic                wr_data;
    logic                pair_last;

    function automatic logic [BFD_NV_W-1:0] popcount(input logic [CNT_W-1:0] value);
        logic [BFD_NV_W-1:0] total;
        total = '0;
        for (int i = 0; i < CNT_W; i++) begin
            total = total + BFD_NV_W'(value[i]);
        end
        return total;
    endfunction

    always_comb
    begin
        if (num_vars_reg == '0)
        begin
            n_eff = BFD_NV_W'(1);
        end
        else if (num_vars_reg > BFD_NV_W'(MAX_VARS))
        begin
            n_eff = BFD_NV_W'(MAX_VARS);
        end
        else
        begin
            n_eff = num_vars_reg;
        end
    end

    assign table_len      = (CNT_W+1)'(1) << n_eff;
    assign half_len       = table_len >> 1;
    assign bit_sel        = CNT_W'(1) << round_reg;
    assign low_mask       = bit_sel - CNT_W'(1);
    assign addr_lo        = ((pair_reg & ~low_mask) << 1) | (pair_reg & low_mask);
    assign addr_hi        = addr_lo | bit_sel;
    assign pair_last      = ({1'b0, pair_reg} + (CNT_W+1)'(1)) == half_len;
    assign sts.load_last  = ({1'b0, count_reg} + (CNT_W+1)'(1)) >= table_len;
    assign sts.xform_last = pair_last && ((BFD_NV_W'(round_reg) + BFD_NV_W'(1)) == n_eff);
    assign sts.scan_last  = ({1'b0, scan_reg} + (CNT_W+1)'(1)) == table_len;
    assign rd0_addr       = cmd.scan ? scan_reg : addr_lo;
    assign wr_en          = cmd.load || cmd.xwrite;
    assign wr_addr        = cmd.load ? count_reg : addr_hi;
    assign wr_data        = cmd.load ? truth_bit : (rd0_reg ^ rd1_reg);
    assign degree         = degree_reg;

    always_comb
    begin
        num_vars_next = cmd.cfg_write ? cfg_data : num_vars_reg;
        count_next    = count_reg;
        round_next    = round_reg;
        pair_next     = pair_reg;
        scan_next     = scan_reg;
        check_next    = cmd.scan;
        weight_next   = popcount(scan_reg);
        best_next     = best_reg;
        if (cmd.load)
        begin
            count_next = sts.load_last ? '0 : count_reg + CNT_W'(1);
            round_next = '0;
            pair_next  = '0;
            scan_next  = '0;
            best_next  = '0;
        end
        if (cmd.xwrite)
        begin
            if (pair_last)
            begin
                pair_next  = '0;
                round_next = round_reg + RND_W'(1);
            end
            else
            begin
                pair_next = pair_reg + CNT_W'(1);
            end
        end
        if (cmd.scan)
        begin
            scan_next = scan_reg + CNT_W'(1);
        end
        if (check_reg && rd0_reg && (weight_reg > best_reg))
        begin
            best_next = weight_reg;
        end
        degree_next = cmd.emit ? best_next : degree_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vars_reg <= BFD_NV_RESET;
            count_reg    <= '0;
            round_reg    <= '0;
            pair_reg     <= '0;
            scan_reg     <= '0;
            check_reg    <= 1'b0;
            weight_reg   <= '0;
            best_reg     <= '0;
        end
        else
        begin
            num_vars_reg <= num_vars_next;
            count_reg    <= count_next;
            round_reg    <= round_next;
            pair_reg     <= pair_next;
            scan_reg     <= scan_next;
            check_reg    <= check_next;
            weight_reg   <= weight_next;
            best_reg     <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (cmd.xread || cmd.scan)
        begin
            rd0_reg <= table_mem[rd0_addr];
        end
        if (cmd.xread)
        begin
            rd1_reg <= table_mem[addr_hi];
        end
        degree_reg <= degree_next;
    end

`ifndef ASSERT_OFF
    a_count_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !sts.load_last) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("load count did not advance");

    a_count_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && sts.load_last) |=> (count_reg == '0))
        else $error("load count did not return to zero after the last entry");

    a_round_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.xread || cmd.xwrite) |-> (BFD_NV_W'(round_reg) < n_eff))
        else $error("butterfly round beyond the number of variables");
`endif

endmodule

### src/bfd_ctrl.sv
// Controller of the Boolean function degree core: load, transform, scan and emit sequence.
// Drives the datapath commands and the channel handshakes. Depends on bfd_pkg.
module bfd_ctrl
    import bfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  bfd_sts_t sts,
    output bfd_cmd_t cmd
);

    bfd_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cfg_ready  = 1'b0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                cfg_ready     = 1'b1;
                in_ready      = !cfg_valid;
                cmd.cfg_write = cfg_valid;
                cmd.load      = in_valid && !cfg_valid;
                if (cmd.load && sts.load_last)
                begin
                    state_next = ST_XREAD;
                end
            end
            ST_XREAD:
            begin
                cmd.xread  = 1'b1;
                state_next = ST_XWRITE;
            end
            ST_XWRITE:
            begin
                cmd.xwrite = 1'b1;
                if (sts.xform_last)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_XREAD;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

`ifndef ASSERT_OFF
    a_last_load_starts_xform: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && sts.load_last) |=> (state_reg == ST_XREAD))
        else $error("last table entry did not start the transform");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted degree not presented");

    a_no_input_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_XREAD || state_reg == ST_XWRITE || state_reg == ST_SCAN)
        |-> !in_ready && !cfg_ready)
        else $error("request taken during transform or scan");
`endif

endmodule

### dv/testbench.sv
// Self-checking testbench for boolean_function_degree_core.
// Loads truth tables and checks each reported degree against a pinned value or an ANF predictor.
// Depends on bfd_pkg and the core RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bfd_pkg::*;

    localparam int TABLE_BITS      = 1 << BFD_MAX_VARS;
    localparam int DRAIN_CYCLES    = 300;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_CYCLES = 20000;
    localparam int ITEM_TARGET     = 700;
    localparam int REPORT_LIMIT    = 10;

    typedef enum int {
        FN_RANDOM,
        FN_ZERO,
        FN_ONE,
        FN_SINGLE,
        FN_TOP,
        FN_LINEAR,
        FN_QUADRATIC
    } fn_shape_t;

    typedef struct packed {
        logic [BFD_NV_W-1:0] nv;
        logic [7:0]          entries;
        logic                pinned;
        logic [BFD_NV_W-1:0] want;
    } fn_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [BFD_NV_W-1:0] cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic                truth_bit = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [BFD_NV_W-1:0] degree;

    logic [BFD_NV_W-1:0] degree_q[$];
    int                  fixed_degree_q[$];
    logic [BFD_NV_W-1:0] pred_nv = BFD_NV_RESET;
    bit [TABLE_BITS-1:0] pred_table;
    int                  pred_count = 0;
    int                  mismatches = 0;
    int                  items_sent = 0;
    bit                  steady     = 1'b0;
    bit                  hold_off   = 1'b0;
    bit                  holding    = 1'b0;

    fn_row_t directed_rows [8] = '{
        '{4'd1, 8'b0000_0000, 1'b1, 4'd0},
        '{4'd1, 8'b0000_0011, 1'b1, 4'd0},
        '{4'd1, 8'b0000_0001, 1'b1, 4'd1},
        '{4'd1, 8'b0000_0010, 1'b1, 4'd1},
        '{4'd0, 8'b0000_0010, 1'b1, 4'd1},
        '{4'd2, 8'b0000_1000, 1'b1, 4'd2},
        '{4'd2, 8'b0000_0110, 1'b0, 4'd0},
        '{4'd3, 8'b1000_0000, 1'b1, 4'd3}
    };

    boolean_function_degree_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .truth_bit (truth_bit),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .degree    (degree)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int eff_vars(logic [BFD_NV_W-1:0] nv);
        if (nv == 0)
            return 1;
        if (nv > BFD_MAX_VARS)
            return BFD_MAX_VARS;
        return int'(nv);
    endfunction

    function automatic logic [BFD_NV_W-1:0] anf_degree(bit [TABLE_BITS-1:0] tbl, int nv);
        bit [TABLE_BITS-1:0] coef;
        int                  span;
        int                  best;
        coef = tbl;
        span = 1 << nv;
        best = 0;
        for (int r = 0; r < nv; r++)
            for (int k = 0; k < span; k++)
                if (k[r])
                    coef[k] = coef[k] ^ coef[k ^ (1 << r)];
        for (int k = 0; k < span; k++)
            if (coef[k] && $countones(k) > best)
                best = $countones(k);
        return best[BFD_NV_W-1:0];
    endfunction

    function automatic bit [TABLE_BITS-1:0] make_fn(fn_shape_t shape, int nv);
        bit [TABLE_BITS-1:0] tbl;
        int                  span;
        int                  m1;
        int                  m2;
        int                  m3;
        bit                  c;
        tbl  = '0;
        span = 1 << nv;
        m1   = $urandom_range(0, TABLE_BITS - 1);
        m2   = $urandom_range(0, TABLE_BITS - 1);
        m3   = $urandom_range(0, TABLE_BITS - 1);
        c    = $urandom_range(0, 1);
        for (int k = 0; k < span; k++)
        begin
            case (shape)
                FN_RANDOM:    tbl[k] = $urandom_range(0, 1);
                FN_ONE:       tbl[k] = 1'b1;
                FN_LINEAR:    tbl[k] = (^(k & m1)) ^ c;
                FN_QUADRATIC: tbl[k] = ((^(k & m1)) & (^(k & m2))) ^ (^(k & m3));
                default:      tbl[k] = 1'b0;
            endcase
        end
        if (shape == FN_SINGLE)
            tbl[$urandom_range(0, span - 1)] = 1'b1;
        if (shape == FN_TOP)
            tbl[span - 1] = 1'b1;
        return tbl;
    endfunction

    function automatic logic [BFD_NV_W-1:0] pick_nv();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return BFD_NV_W'($urandom_range(8, 15));
        if (r < 15)
            return BFD_NV_W'($urandom_range(6, 7));
        if (r < 22)
            return '0;
        return BFD_NV_W'($urandom_range(1, 5));
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    task automatic send_entry(bit b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        truth_bit <= b;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic send_table(bit [TABLE_BITS-1:0] tbl, int nv);
        for (int k = 0; k < (1 << nv); k++)
            send_entry(tbl[k]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (degree_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_num_vars(logic [BFD_NV_W-1:0] nv);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= nv;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : track
        logic [BFD_NV_W-1:0] want_deg;
        int                  fixed;
        if (!rst_n)
        begin
            pred_nv    = BFD_NV_RESET;
            pred_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (degree_q.size() == 0)
                    flag_mismatch($sformatf("degree %0d with none expected", degree));
                else
                begin
                    want_deg = degree_q.pop_front();
                    if (degree !== want_deg)
                        flag_mismatch($sformatf("degree expected %0d, got %0d",
                                                want_deg, degree));
                end
            end
            if (cfg_valid && cfg_ready)
                pred_nv = cfg_data;
            if (in_valid && in_ready)
            begin
                pred_table[pred_count] = truth_bit;
                if (pred_count + 1 >= (1 << eff_vars(pred_nv)))
                begin
                    fixed = (fixed_degree_q.size() != 0) ? fixed_degree_q.pop_front() : -1;
                    if (fixed >= 0)
                        degree_q.push_back(fixed[BFD_NV_W-1:0]);
                    else
                        degree_q.push_back(anf_degree(pred_table, eff_vars(pred_nv)));
                    pred_count = 0;
                end
                else
                    pred_count++;
            end
        end
    end

    initial
    begin
        int r;
        forever
        begin
            if (hold_off)
            begin
                hold_off  = 1'b0;
                holding   = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding   = 1'b0;
            end
            else if (steady)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
                else if (r < 92)
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(15, 60)) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [BFD_NV_W-1:0] nv_cfg;
        fn_shape_t           shape;
        int                  nv;
        int                  ntab;
        int                  phase;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (i == 0 || directed_rows[i].nv != directed_rows[i-1].nv)
                write_num_vars(directed_rows[i].nv);
            fixed_degree_q.push_back(directed_rows[i].pinned ? int'(directed_rows[i].want) : -1);
            send_table(TABLE_BITS'(directed_rows[i].entries), eff_vars(directed_rows[i].nv));
        end

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase == 0)
                nv_cfg = 4'd15;
            else if (phase == 1)
                nv_cfg = 4'd1;
            else
                nv_cfg = pick_nv();
            write_num_vars(nv_cfg);
            nv     = eff_vars(nv_cfg);
            steady = (phase == 1) || ($urandom_range(0, 4) == 0);
            if (phase == 1)
            begin
                hold_off = 1'b1;
                while (!holding)
                    @(posedge clk);
            end
            if (phase == 0)
                ntab = 1;
            else if (phase == 1)
                ntab = 12;
            else
                ntab = (nv <= 5) ? $urandom_range(1, 6) : 1;
            for (int t = 0; t < ntab; t++)
            begin
                shape = (phase == 0) ? FN_TOP : fn_shape_t'($urandom_range(0, FN_QUADRATIC));
                fixed_degree_q.push_back(-1);
                send_table(make_fn(shape, nv), nv);
            end
            phase++;
        end

        drain();
        if (degree_q.size() != 0)
            flag_mismatch($sformatf("%0d degrees never reported", degree_q.size()));
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

### sim.f
src/bfd_pkg.sv
src/bfd_datapath.sv
src/bfd_ctrl.sv
src/boolean_function_degree_core.sv
dv/testbench.sv
